@@ design/dvre_pkg.sv @@
// dvre_pkg: shared constants, queue entry type and engine states of the
// distance-vector route engine; no dependencies
package dvre_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int COST_BITS_DEF = 16;
  localparam int COST_MAX_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [0:0] REG_SELF_ID    = 1'b0;
  localparam logic [0:0] REG_NODE_COUNT = 1'b1;

  localparam logic ACT_LINK   = 1'b0;
  localparam logic KIND_ROUTE = 1'b0;
  localparam logic KIND_ADV   = 1'b1;

  typedef struct packed {
    logic                     is_vec;
    logic                     last;
    logic                     node_ok;
    logic                     dest_ok;
    logic [3:0]               node;
    logic [3:0]               dest;
    logic [COST_MAX_BITS-1:0] cost;
    logic                     cost_inf;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK_DIRECT,
    S_LINK_SCAN,
    S_VEC_WR,
    S_RC_INIT,
    S_RC_SCAN,
    S_RC_OWN,
    S_RC_CMP,
    S_ADV_RD,
    S_ADV_OUT
  } st_t;

endpackage

@@ design/dvre_front.sv @@
// dvre_front: accepts input beats, clamps the cost and checks the indices
// depends on dvre_pkg
module dvre_front #(
  parameter int MAX_NODES = dvre_pkg::MAX_NODES_DEF,
  parameter int COST_BITS = dvre_pkg::COST_BITS_DEF
) (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [3:0]    in_node_id,
  input  logic [3:0]    in_dest_index,
  input  logic [15:0]   in_cost_value,
  input  logic          in_last,
  input  logic          clearing,
  input  logic          q_ready,
  output logic          q_push,
  output dvre_pkg::cmd_t q_data
);

  localparam logic [31:0] INF32 = 32'((64'd1 << COST_BITS) - 64'd1);

  logic [31:0] cost32;

  assign cost32   = 32'(in_cost_value);
  assign in_ready = q_ready && !clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data          = '0;
    q_data.is_vec   = (in_action != dvre_pkg::ACT_LINK);
    q_data.last     = in_last;
    q_data.node_ok  = (32'(in_node_id) < MAX_NODES);
    q_data.dest_ok  = (32'(in_dest_index) < MAX_NODES);
    q_data.node     = in_node_id;
    q_data.dest     = in_dest_index;
    q_data.cost_inf = (cost32 >= INF32);
    q_data.cost     = q_data.cost_inf ? INF32 : cost32;
  end

endmodule

@@ design/dvre_queue.sv @@
// dvre_queue: short first-in first-out queue between front and back
// depends on nothing
module dvre_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign ready    = (32'(cnt_r) < DEPTH);
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && valid)) cnt_nxt = cnt_r + CW'(1);
    else if (!push && pop && valid) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + PW'(1);
      if (pop && valid) rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

@@ design/dvre_back.sv @@
// dvre_back: route tables, bellman-ford recompute sequencer and result register
// depends on dvre_pkg
module dvre_back #(
  parameter int MAX_NODES = dvre_pkg::MAX_NODES_DEF,
  parameter int COST_BITS = dvre_pkg::COST_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [3:0]     self_id,
  input  logic [4:0]     node_count,
  output logic           clearing,
  input  logic           q_valid,
  input  dvre_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [3:0]     out_dest,
  output logic [4:0]     out_hop,
  output logic [15:0]    out_cost,
  output logic           out_last_result
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int HW  = $clog2(MAX_NODES + 1);
  localparam int AW  = 2 * NIW;
  localparam int CB  = COST_BITS;
  localparam logic [CB-1:0] INF    = {CB{1'b1}};
  localparam logic [HW-1:0] NO_HOP = HW'(MAX_NODES);

  dvre_pkg::st_t  state_r, state_nxt;
  dvre_pkg::cmd_t cmd_r;

  logic [CB-1:0]  vt_mem [2**AW];
  logic [CB-1:0]  link_r [MAX_NODES];
  logic [HW-1:0]  nh_r   [MAX_NODES];

  logic [AW-1:0]  clr_r;
  logic [NIW-1:0] n_r, h_r, ph_r;
  logic           pv_r, changed_r;
  logic [CB-1:0]  best_r, rd_r;
  logic [HW-1:0]  besth_r;

  logic [HW-1:0]  cnt_m1;
  logic           last_n, last_h, self_ok, can_emit;
  logic [NIW-1:0] self_idx, node_idx, dest_idx;
  logic           scan_match, own_diff;
  logic [CB-1:0]  own_cost, lk, cand;
  logic [CB:0]    sum;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_a;
  logic [CB-1:0]  mem_wd;
  logic           nh_we, link_we, emit, emit_kind, emit_last;
  logic [NIW-1:0] nh_wa;
  logic [HW-1:0]  nh_wd;
  logic [31:0]    emit_dest, emit_hop;
  logic [CB-1:0]  emit_cost;

  always_comb begin
    if (node_count == 5'd0) cnt_m1 = '0;
    else if (32'(node_count) > MAX_NODES) cnt_m1 = HW'(MAX_NODES - 1);
    else cnt_m1 = HW'(node_count - 5'd1);
  end

  assign last_n     = (HW'(n_r) == cnt_m1);
  assign last_h     = (HW'(h_r) == cnt_m1);
  assign self_ok    = (32'(self_id) < MAX_NODES);
  assign self_idx   = NIW'(self_id);
  assign node_idx   = NIW'(cmd_r.node);
  assign dest_idx   = NIW'(cmd_r.dest);
  assign can_emit   = !out_valid || out_ready;
  assign clearing   = (state_r == dvre_pkg::S_CLEAR);
  assign scan_match = (32'(nh_r[n_r]) == 32'(cmd_r.node));
  assign own_cost   = self_ok ? rd_r : INF;
  assign own_diff   = (own_cost != best_r);

  assign lk   = link_r[ph_r];
  assign sum  = {1'b0, lk} + {1'b0, rd_r};
  assign cand = (ph_r == n_r) ? lk : ((sum >= {1'b0, INF}) ? INF : sum[CB-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dvre_pkg::S_CLEAR:       if (clr_r == '1) state_nxt = dvre_pkg::S_IDLE;
      dvre_pkg::S_IDLE: begin
        if (q_valid) state_nxt = q_data.is_vec ? dvre_pkg::S_VEC_WR : dvre_pkg::S_LINK_DIRECT;
      end
      dvre_pkg::S_LINK_DIRECT: begin
        if (can_emit) state_nxt = cmd_r.cost_inf ? dvre_pkg::S_LINK_SCAN : dvre_pkg::S_RC_INIT;
      end
      dvre_pkg::S_LINK_SCAN: begin
        if ((!scan_match || can_emit) && last_n) state_nxt = dvre_pkg::S_RC_INIT;
      end
      dvre_pkg::S_VEC_WR:      state_nxt = cmd_r.last ? dvre_pkg::S_RC_INIT : dvre_pkg::S_IDLE;
      dvre_pkg::S_RC_INIT:     state_nxt = dvre_pkg::S_RC_SCAN;
      dvre_pkg::S_RC_SCAN:     if (last_h) state_nxt = dvre_pkg::S_RC_OWN;
      dvre_pkg::S_RC_OWN:      state_nxt = dvre_pkg::S_RC_CMP;
      dvre_pkg::S_RC_CMP: begin
        if (!own_diff || can_emit) begin
          if (!last_n) state_nxt = dvre_pkg::S_RC_INIT;
          else if (!cmd_r.is_vec || changed_r || own_diff) state_nxt = dvre_pkg::S_ADV_RD;
          else state_nxt = dvre_pkg::S_IDLE;
        end
      end
      dvre_pkg::S_ADV_RD:      state_nxt = dvre_pkg::S_ADV_OUT;
      dvre_pkg::S_ADV_OUT: begin
        if (can_emit) state_nxt = last_n ? dvre_pkg::S_IDLE : dvre_pkg::S_ADV_RD;
      end
      default:                 state_nxt = dvre_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_a     = '0;
    mem_wd    = INF;
    nh_we     = 1'b0;
    nh_wa     = '0;
    nh_wd     = '0;
    link_we   = 1'b0;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_kind = dvre_pkg::KIND_ROUTE;
    emit_last = 1'b0;
    emit_dest = 32'(n_r);
    emit_hop  = '0;
    emit_cost = INF;
    case (state_r)
      dvre_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_a  = clr_r;
        mem_wd = (clr_r == '0) ? '0 : INF;
      end
      dvre_pkg::S_IDLE:        q_pop = q_valid;
      dvre_pkg::S_LINK_DIRECT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_dest = 32'(cmd_r.node);
          emit_hop  = 32'(cmd_r.node);
          emit_cost = CB'(cmd_r.cost);
          mem_we    = self_ok && cmd_r.node_ok;
          mem_a     = {self_idx, node_idx};
          mem_wd    = CB'(cmd_r.cost);
          nh_we     = cmd_r.node_ok;
          nh_wa     = node_idx;
          nh_wd     = HW'(cmd_r.node);
          link_we   = cmd_r.node_ok;
        end
      end
      dvre_pkg::S_LINK_SCAN: begin
        if (scan_match && can_emit) begin
          emit     = 1'b1;
          emit_hop = 32'(cmd_r.node);
        end
      end
      dvre_pkg::S_VEC_WR: begin
        mem_we = cmd_r.node_ok && cmd_r.dest_ok;
        mem_a  = {node_idx, dest_idx};
        mem_wd = CB'(cmd_r.cost);
      end
      dvre_pkg::S_RC_INIT: ;
      dvre_pkg::S_RC_SCAN: begin
        mem_re = 1'b1;
        mem_a  = {h_r, n_r};
      end
      dvre_pkg::S_RC_OWN, dvre_pkg::S_ADV_RD: begin
        mem_re = self_ok;
        mem_a  = {self_idx, n_r};
      end
      dvre_pkg::S_RC_CMP: begin
        if (own_diff && can_emit) begin
          emit      = 1'b1;
          emit_hop  = 32'(besth_r);
          emit_cost = best_r;
          mem_we    = self_ok;
          mem_a     = {self_idx, n_r};
          mem_wd    = best_r;
          nh_we     = 1'b1;
          nh_wa     = n_r;
          nh_wd     = besth_r;
        end
      end
      dvre_pkg::S_ADV_OUT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_kind = dvre_pkg::KIND_ADV;
          emit_cost = own_cost;
          emit_last = last_n;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dvre_pkg::S_CLEAR;
      clr_r     <= '0;
      out_valid <= 1'b0;
      pv_r      <= 1'b0;
      changed_r <= 1'b0;
      n_r       <= '0;
      h_r       <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        link_r[i] <= INF;
        nh_r[i]   <= (i == 0) ? '0 : NO_HOP;
      end
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + AW'(1);
      pv_r <= (state_r == dvre_pkg::S_RC_SCAN);
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (link_we) link_r[node_idx] <= CB'(cmd_r.cost);
      if (nh_we) nh_r[nh_wa] <= nh_wd;
      if (state_r == dvre_pkg::S_IDLE) changed_r <= 1'b0;
      else if (state_r == dvre_pkg::S_RC_CMP && emit) changed_r <= 1'b1;
      case (state_r)
        dvre_pkg::S_IDLE, dvre_pkg::S_LINK_DIRECT: n_r <= '0;
        dvre_pkg::S_LINK_SCAN: begin
          if (!scan_match || can_emit) n_r <= last_n ? '0 : n_r + NIW'(1);
        end
        dvre_pkg::S_RC_CMP: begin
          if (!own_diff || can_emit) n_r <= last_n ? '0 : n_r + NIW'(1);
        end
        dvre_pkg::S_ADV_OUT:   if (can_emit) n_r <= n_r + NIW'(1);
        default: ;
      endcase
      if (state_r == dvre_pkg::S_RC_INIT) h_r <= '0;
      else if (state_r == dvre_pkg::S_RC_SCAN) h_r <= h_r + NIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == dvre_pkg::S_IDLE && q_valid) cmd_r <= q_data;
    ph_r <= h_r;
    if (state_r == dvre_pkg::S_RC_INIT) begin
      best_r  <= (32'(n_r) == 32'(self_id)) ? '0 : INF;
      besth_r <= (32'(n_r) == 32'(self_id)) ? HW'(n_r) : NO_HOP;
    end else if (pv_r && (32'(ph_r) != 32'(self_id)) && (cand < best_r)) begin
      best_r  <= cand;
      besth_r <= HW'(ph_r);
    end
    if (emit) begin
      out_kind        <= emit_kind;
      out_dest        <= 4'(emit_dest);
      out_hop         <= 5'(emit_hop);
      out_cost        <= 16'(emit_cost);
      out_last_result <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) vt_mem[mem_a] <= mem_wd;
    if (mem_re) rd_r <= vt_mem[mem_a];
  end

`ifndef ASSERT_OFF
  a_last_is_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_kind == dvre_pkg::KIND_ADV)
    else $error("final beat is not an advertisement entry");
  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result during clearing pass");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == dvre_pkg::S_IDLE && !clearing)
    else $error("queue popped while busy");
  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(state_r) == dvre_pkg::S_RC_SCAN)
    else $error("scan data without a scan read");
`endif

endmodule

@@ design/distance_vector_route_engine_top.sv @@
// distance_vector_route_engine_top: register port, front, queue and back of the
// distance-vector route engine; depends on dvre_pkg, dvre_front, dvre_queue, dvre_back
// a link beat passes the queue and is popped when the back is idle; its first result
// is registered in the link state once the output can take it. A recompute scans the
// table one read at a time, set by the single port of the vector memory; advertising emits one entry per node
// a vector element with last low is written to the table and the back returns to idle
// reset: a clearing pass writes every entry of the vector table, no beat taken during it
module distance_vector_route_engine_top #(
  parameter int MAX_NODES = dvre_pkg::MAX_NODES_DEF,
  parameter int COST_BITS = dvre_pkg::COST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_node_id,
  input  logic [3:0]  in_dest_index,
  input  logic [15:0] in_cost_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [3:0]  out_dest,
  output logic [4:0]  out_hop,
  output logic [15:0] out_cost,
  output logic        out_last_result
);

  localparam int QW = $bits(dvre_pkg::cmd_t);

  logic [3:0]     self_id_r;
  logic [4:0]     node_count_r;
  logic           clearing, q_push, q_ready, q_valid, q_pop;
  dvre_pkg::cmd_t f_data, b_data;
  logic [QW-1:0]  q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dvre_pkg::REG_SELF_ID) ? 32'(self_id_r) : 32'(node_count_r);
  assign b_data = dvre_pkg::cmd_t'(q_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r    <= 4'd0;
      node_count_r <= 5'd16;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        dvre_pkg::REG_SELF_ID:    self_id_r    <= pwdata[3:0];
        dvre_pkg::REG_NODE_COUNT: node_count_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  dvre_front #(.MAX_NODES(MAX_NODES), .COST_BITS(COST_BITS)) u_front (
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_node_id(in_node_id), .in_dest_index(in_dest_index),
    .in_cost_value(in_cost_value), .in_last(in_last), .clearing(clearing),
    .q_ready(q_ready), .q_push(q_push), .q_data(f_data)
  );

  dvre_queue #(.WIDTH(QW), .DEPTH(dvre_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(f_data), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .pop_data(q_out)
  );

  dvre_back #(.MAX_NODES(MAX_NODES), .COST_BITS(COST_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .self_id(self_id_r), .node_count(node_count_r),
    .clearing(clearing), .q_valid(q_valid), .q_data(b_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_dest(out_dest), .out_hop(out_hop), .out_cost(out_cost),
    .out_last_result(out_last_result)
  );

endmodule
